// ===== sv/zcst_pkg.sv =====
// shared constants, command codes and status bundle for the zero count segment tree
package zcst_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int KIND_W    = 2;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int RANK_W    = 11;
    localparam int CNT_OUT_W = 11;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COUNT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_LOAD,
        CMD_WLEAF,
        CMD_WUP,
        CMD_QISSUE,
        CMD_QSTEP,
        CMD_QLAST,
        CMD_QEVAL,
        CMD_FSTEP,
        CMD_OUT
    } dp_cmd_t;

    typedef struct packed {
        logic init_last;
        logic write_ok;
        logic is_query;
        logic find_go;
    } dp_stat_t;

endpackage

// ===== sv/zcst_ram.sv =====
// generic simple dual port ram, one write port and two registered read ports
module zcst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== sv/zcst_dp.sv =====
// datapath: item registers, tree walk registers, node memory and result registers
module zcst_dp #(
    parameter int CAPACITY = zcst_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  zcst_pkg::dp_cmd_t                 cmd,
    output zcst_pkg::dp_stat_t                stat,
    input  logic [zcst_pkg::KIND_W-1:0]       kind,
    input  logic [zcst_pkg::IDX_W-1:0]        left_or_slot,
    input  logic [zcst_pkg::IDX_W-1:0]        right_end,
    input  logic signed [zcst_pkg::VAL_W-1:0] new_value,
    input  logic [zcst_pkg::RANK_W-1:0]       rank,
    output logic [zcst_pkg::CNT_OUT_W-1:0]    zero_count,
    output logic                              found,
    output logic [zcst_pkg::IDX_W-1:0]        found_slot
);

    localparam int L     = $clog2(CAPACITY);
    localparam int P     = 1 << L;
    localparam int AW    = L + 1;
    localparam int DEPTH = 2 * P;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int LW    = L + 1;
    localparam int XW    = (L > zcst_pkg::IDX_W) ? L : zcst_pkg::IDX_W;
    localparam int KW    = ((zcst_pkg::RANK_W > CW) ? zcst_pkg::RANK_W : CW) + 1;
    localparam int OW    = zcst_pkg::CNT_OUT_W;

    localparam logic [XW-1:0] CAP_M1 = XW'(CAPACITY - 1);
    localparam logic [LW-1:0] CAP_L  = LW'(CAPACITY);
    localparam logic [LW-1:0] P_L    = LW'(P);

    // item registers
    logic [zcst_pkg::KIND_W-1:0] kind_reg;
    logic [zcst_pkg::RANK_W-1:0] rank_reg;
    logic                        z_reg;
    logic                        empty_reg;
    logic                        slot_ok_reg;

    // walk registers
    logic [AW-1:0] vl_reg;
    logic [AW-1:0] vr_reg;
    logic          addl_reg;
    logic          addr_reg;
    logic [CW-1:0] pl_reg;
    logic [CW-1:0] pr_reg;
    logic [CW-1:0] cur_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] cnt_reg;
    logic          ok_reg;

    // reset sweep registers
    logic [AW-1:0] iv_reg;
    logic [LW-1:0] base_reg;
    logic [LW-1:0] size_reg;

    // result registers
    logic [zcst_pkg::CNT_OUT_W-1:0] zero_count_reg;
    logic                           found_reg;
    logic [zcst_pkg::IDX_W-1:0]     found_slot_reg;

    // memory ports
    logic          we;
    logic [AW-1:0] waddr;
    logic [CW-1:0] wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [CW-1:0] rdata_a;
    logic [CW-1:0] rdata_b;

    zcst_ram #(
        .WIDTH(CW),
        .DEPTH(DEPTH)
    ) u_nodes (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b)
    );

    // input decode
    logic [XW-1:0] l_w;
    logic [XW-1:0] r_w;
    logic [XW-1:0] r_clip;

    assign l_w    = XW'(left_or_slot);
    assign r_w    = XW'(right_end);
    assign r_clip = (r_w > CAP_M1) ? CAP_M1 : r_w;

    // reset count of the node under the sweep
    logic [LW-1:0] init_rem;
    logic [LW-1:0] init_cnt;
    logic [LW-1:0] base_end;

    assign init_rem = CAP_L - base_reg;
    assign init_cnt = (base_reg >= CAP_L) ? '0 : ((init_rem > size_reg) ? size_reg : init_rem);
    assign base_end = base_reg + size_reg;

    // arithmetic
    logic [CW-1:0] up_sum;
    logic [CW-1:0] acc_l;
    logic [CW-1:0] acc_r;
    logic [CW-1:0] cnt_c;
    logic [KW-1:0] rank_w;
    logic [KW-1:0] kq_w;
    logic          find_go;
    logic          go_left;
    logic [AW-1:0] f_v_next;
    logic [CW-1:0] f_k_next;
    logic [XW-1:0] slot_w;

    assign up_sum   = cur_reg + rdata_a;
    assign acc_l    = pl_reg + (addl_reg ? rdata_a : '0);
    assign acc_r    = pr_reg + (addr_reg ? rdata_b : '0);
    assign cnt_c    = pr_reg - pl_reg;
    assign rank_w   = KW'(rank_reg);
    assign kq_w     = KW'(pl_reg) + rank_w;
    assign find_go  = (kind_reg == zcst_pkg::KIND_FIND) && !empty_reg
                      && (rank_reg != '0) && (rank_w <= KW'(cnt_c));
    assign go_left  = (rdata_a >= k_reg);
    assign f_v_next = {vl_reg[AW-2:0], ~go_left};
    assign f_k_next = go_left ? k_reg : (k_reg - rdata_a);
    assign slot_w   = XW'(vl_reg[L-1:0]);

    always_comb
    begin
        we      = 1'b0;
        waddr   = '0;
        wdata   = '0;
        raddr_a = '0;
        raddr_b = '0;
        case (cmd)
            zcst_pkg::CMD_INIT:
            begin
                we    = 1'b1;
                waddr = iv_reg;
                wdata = CW'(init_cnt);
            end
            zcst_pkg::CMD_WLEAF:
            begin
                we      = 1'b1;
                waddr   = vl_reg;
                wdata   = CW'(z_reg);
                raddr_a = vl_reg ^ AW'(1);
            end
            zcst_pkg::CMD_WUP:
            begin
                we      = 1'b1;
                waddr   = vl_reg >> 1;
                wdata   = up_sum;
                raddr_a = (vl_reg >> 1) ^ AW'(1);
            end
            zcst_pkg::CMD_QISSUE:
            begin
                raddr_a = vl_reg ^ AW'(1);
                raddr_b = vr_reg;
            end
            zcst_pkg::CMD_QSTEP:
            begin
                raddr_a = vl_reg ^ AW'(1);
                raddr_b = vr_reg ^ AW'(1);
            end
            zcst_pkg::CMD_QEVAL:
            begin
                raddr_a = AW'(2);
            end
            zcst_pkg::CMD_FSTEP:
            begin
                raddr_a = {f_v_next[AW-2:0], 1'b0};
            end
            default:
            begin
                raddr_a = '0;
            end
        endcase
    end

    assign stat.init_last = (iv_reg == AW'(DEPTH - 1));
    assign stat.write_ok  = (kind_reg == zcst_pkg::KIND_WRITE) && slot_ok_reg;
    assign stat.is_query  = (kind_reg == zcst_pkg::KIND_COUNT) || (kind_reg == zcst_pkg::KIND_FIND);
    assign stat.find_go   = find_go;

    // sweep position, reset at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg   <= AW'(1);
            base_reg <= '0;
            size_reg <= P_L;
        end
        else if (cmd == zcst_pkg::CMD_INIT)
        begin
            iv_reg <= iv_reg + AW'(1);
            if (base_end == P_L)
            begin
                base_reg <= '0;
                size_reg <= size_reg >> 1;
            end
            else
            begin
                base_reg <= base_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            zcst_pkg::CMD_LOAD:
            begin
                kind_reg    <= kind;
                rank_reg    <= rank;
                z_reg       <= (new_value == '0);
                empty_reg   <= (l_w > r_clip);
                slot_ok_reg <= (l_w <= CAP_M1);
                vl_reg      <= {1'b1, l_w[L-1:0]};
                vr_reg      <= {1'b1, r_clip[L-1:0]};
            end
            zcst_pkg::CMD_WLEAF:
            begin
                cur_reg <= CW'(z_reg);
            end
            zcst_pkg::CMD_WUP:
            begin
                cur_reg <= up_sum;
                vl_reg  <= vl_reg >> 1;
            end
            zcst_pkg::CMD_QISSUE:
            begin
                pl_reg   <= '0;
                pr_reg   <= '0;
                addl_reg <= vl_reg[0] && (vl_reg != AW'(1));
                addr_reg <= 1'b1;
                vl_reg   <= vl_reg >> 1;
            end
            zcst_pkg::CMD_QSTEP:
            begin
                pl_reg   <= acc_l;
                pr_reg   <= acc_r;
                addl_reg <= vl_reg[0] && (vl_reg != AW'(1));
                addr_reg <= vr_reg[0] && (vr_reg != AW'(1));
                vl_reg   <= vl_reg >> 1;
                vr_reg   <= vr_reg >> 1;
            end
            zcst_pkg::CMD_QLAST:
            begin
                pl_reg <= acc_l;
                pr_reg <= acc_r;
            end
            zcst_pkg::CMD_QEVAL:
            begin
                cnt_reg <= empty_reg ? '0 : cnt_c;
                ok_reg  <= find_go;
                k_reg   <= kq_w[CW-1:0];
                vl_reg  <= AW'(1);
            end
            zcst_pkg::CMD_FSTEP:
            begin
                vl_reg <= f_v_next;
                k_reg  <= f_k_next;
            end
            zcst_pkg::CMD_OUT:
            begin
                if (kind_reg == zcst_pkg::KIND_COUNT)
                begin
                    zero_count_reg <= OW'(cnt_reg);
                    found_reg      <= 1'b0;
                    found_slot_reg <= '0;
                end
                else
                begin
                    zero_count_reg <= '0;
                    found_reg      <= ok_reg;
                    found_slot_reg <= ok_reg ? slot_w[zcst_pkg::IDX_W-1:0] : '0;
                end
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    assign zero_count = zero_count_reg;
    assign found      = found_reg;
    assign found_slot = found_slot_reg;

`ifndef NO_ASSERTIONS
    a_prefix_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == zcst_pkg::CMD_QEVAL && !empty_reg) |-> (pr_reg >= pl_reg))
        else $error("right prefix below left prefix");

    a_find_at_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == zcst_pkg::CMD_OUT && ok_reg) |-> vl_reg[AW-1])
        else $error("rank search ended above leaf level");

    a_up_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == zcst_pkg::CMD_WUP) |-> (up_sum <= CW'(CAPACITY)))
        else $error("node count exceeds capacity");
`endif

endmodule

// ===== sv/zcst_ctrl.sv =====
// controller: sequences reset sweep, slot writes, range queries and rank searches
module zcst_ctrl #(
    parameter int CAPACITY = zcst_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output zcst_pkg::dp_cmd_t  cmd,
    input  zcst_pkg::dp_stat_t stat
);

    localparam int L   = $clog2(CAPACITY);
    localparam int LVW = (L > 1) ? $clog2(L) : 1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_WUP,
        S_QSTEP,
        S_QLAST,
        S_QEVAL,
        S_FIND,
        S_RESULT
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [LVW-1:0] lvl_reg;
    logic [LVW-1:0] lvl_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           lvl_last;

    assign lvl_last = (lvl_reg == LVW'(L - 1));

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg;
        cmd            = zcst_pkg::CMD_NONE;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_INIT:
            begin
                cmd = zcst_pkg::CMD_INIT;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = zcst_pkg::CMD_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                lvl_next = '0;
                if (stat.write_ok)
                begin
                    cmd        = zcst_pkg::CMD_WLEAF;
                    state_next = S_WUP;
                end
                else if (stat.is_query)
                begin
                    cmd        = zcst_pkg::CMD_QISSUE;
                    state_next = S_QSTEP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WUP:
            begin
                cmd      = zcst_pkg::CMD_WUP;
                lvl_next = lvl_reg + LVW'(1);
                if (lvl_last)
                begin
                    lvl_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_QSTEP:
            begin
                cmd      = zcst_pkg::CMD_QSTEP;
                lvl_next = lvl_reg + LVW'(1);
                if (lvl_last)
                begin
                    lvl_next   = '0;
                    state_next = S_QLAST;
                end
            end
            S_QLAST:
            begin
                cmd        = zcst_pkg::CMD_QLAST;
                state_next = S_QEVAL;
            end
            S_QEVAL:
            begin
                cmd        = zcst_pkg::CMD_QEVAL;
                lvl_next   = '0;
                state_next = stat.find_go ? S_FIND : S_RESULT;
            end
            S_FIND:
            begin
                cmd      = zcst_pkg::CMD_FSTEP;
                lvl_next = lvl_reg + LVW'(1);
                if (lvl_last)
                begin
                    lvl_next   = '0;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = zcst_pkg::CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd == zcst_pkg::CMD_OUT))
        else $error("result valid without result load");

    a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START) |-> $past(in_valid && in_ready))
        else $error("dispatch without accepted beat");

    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVW'(L - 1))
        else $error("level counter out of range");
`endif

endmodule

// ===== sv/zero_count_segment_tree_top.sv =====
// top level of the zero count segment tree: controller plus datapath
//
// input channel (in_valid/in_ready) carries one item per beat: kind 0 writes
// new_value's zero flag into slot left_or_slot, kind 1 counts zero slots in
// [left_or_slot, right_end], kind 2 finds the rank-th zero in that range.
// kind 3 and writes past the table are dropped; writes give no result beat.
// output channel (out_valid/out_ready) carries zero_count for counts and
// found/found_slot for rank searches, one beat per query.
// L below is log2 of the padded capacity (10 at the default size); the node
// memory is walked one tree level per cycle: a write climbs from its leaf to
// the root, a query walks up from both range ends, and a rank search that can
// succeed then descends L levels from the root to a leaf.
// one item is in flight at a time; in_ready is high only when idle.
// after reset the node memory is swept with the counts of an all-zero table,
// one node a cycle from the root down to the last leaf, with in_ready low
// the whole time.
// a finished result sits in the output register; if the receiver stalls the
// block still takes new beats, and a later query waits only at its own result
// until the earlier beat is taken.
module zero_count_segment_tree_top #(
    parameter int CAPACITY = zcst_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [zcst_pkg::KIND_W-1:0]       kind,
    input  logic [zcst_pkg::IDX_W-1:0]        left_or_slot,
    input  logic [zcst_pkg::IDX_W-1:0]        right_end,
    input  logic signed [zcst_pkg::VAL_W-1:0] new_value,
    input  logic [zcst_pkg::RANK_W-1:0]       rank,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [zcst_pkg::CNT_OUT_W-1:0]    zero_count,
    output logic                              found,
    output logic [zcst_pkg::IDX_W-1:0]        found_slot
);

    // command and status between the sequencer and the datapath
    zcst_pkg::dp_cmd_t  cmd;
    zcst_pkg::dp_stat_t stat;

    // sequencer: handshakes, level counter, result hold
    zcst_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // datapath: item latch, tree walks, node memory, result register
    zcst_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .left_or_slot(left_or_slot),
        .right_end   (right_end),
        .new_value   (new_value),
        .rank        (rank),
        .zero_count  (zero_count),
        .found       (found),
        .found_slot  (found_slot)
    );

endmodule

// ===== tb/sv/zero_count_segment_tree_top_test.sv =====
// self-checking testbench for the zero count segment tree top level

typedef struct packed {
    logic [zcst_pkg::CNT_OUT_W-1:0] zero_count;
    logic                           found;
    logic [zcst_pkg::IDX_W-1:0]     found_slot;
} zero_answer_t;

class zero_table_tracker;
    // one zero flag per slot, all set after reset since every slot starts at zero
    bit           zero_flag[zcst_pkg::CAPACITY_DEF];
    zero_answer_t owed_answers[$];
    int           mismatches;
    int           checked;
    int           writes;
    int           counts;
    int           finds;
    int           located;
    int           spare_beats;

    function new();
        foreach (zero_flag[i])
            zero_flag[i] = 1'b1;
    endfunction

    function int count_zeros(int lo_slot, int hi_slot);
        int total;
        total = 0;
        for (int i = lo_slot; i <= hi_slot; i++)
            total += zero_flag[i];
        return total;
    endfunction

    function void note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void take_item(logic [zcst_pkg::KIND_W-1:0] k_kind,
                            logic [zcst_pkg::IDX_W-1:0] lo_slot,
                            logic [zcst_pkg::IDX_W-1:0] hi_slot,
                            logic [zcst_pkg::VAL_W-1:0] value,
                            logic [zcst_pkg::RANK_W-1:0] k_rank);
        zero_answer_t ans;
        int           total;
        int           seen;
        ans = '0;
        if (k_kind == zcst_pkg::KIND_WRITE)
        begin
            zero_flag[lo_slot] = (value == '0);
            writes++;
            return;
        end
        if (k_kind != zcst_pkg::KIND_COUNT && k_kind != zcst_pkg::KIND_FIND)
        begin
            spare_beats++;
            return;
        end
        total = (lo_slot > hi_slot) ? 0 : count_zeros(lo_slot, hi_slot);
        if (k_kind == zcst_pkg::KIND_COUNT)
        begin
            ans.zero_count = zcst_pkg::CNT_OUT_W'(total);
            counts++;
        end
        else
        begin
            finds++;
            if (k_rank != 0 && k_rank <= total)
            begin
                seen = 0;
                for (int i = lo_slot; i <= hi_slot; i++)
                begin
                    seen += zero_flag[i];
                    if (zero_flag[i] && seen == k_rank)
                    begin
                        ans.found      = 1'b1;
                        ans.found_slot = zcst_pkg::IDX_W'(i);
                        break;
                    end
                end
                located++;
            end
        end
        owed_answers.push_back(ans);
    endfunction

    function void check_answer(logic [zcst_pkg::CNT_OUT_W-1:0] zc, logic f,
                               logic [zcst_pkg::IDX_W-1:0] fs);
        zero_answer_t exp;
        if (owed_answers.size() == 0)
        begin
            note_mismatch($sformatf(
                "result beat with nothing outstanding (count %0d found %b slot %0d)",
                zc, f, fs));
            return;
        end
        exp = owed_answers.pop_front();
        checked++;
        if (zc !== exp.zero_count || f !== exp.found || fs !== exp.found_slot)
            note_mismatch($sformatf(
                "expected count %0d found %b slot %0d, got count %0d found %b slot %0d",
                exp.zero_count, exp.found, exp.found_slot, zc, f, fs));
    endfunction
endclass

module zero_count_segment_tree_top_test;
    import zcst_pkg::*;

    // kind 3 has no meaning; the block should swallow it without a result
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int SLOTS        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1600;
    // the limit must cover the node memory sweep after reset and every item plus
    // sender gaps and receiver stalls; this value is many times what they need
    localparam int CYCLE_LIMIT  = 1_000_000;
    // writes end with no result beat, let them finish before the end check
    localparam int SETTLE       = 40;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         left_or_slot;
    logic [IDX_W-1:0]         right_end;
    logic signed [VAL_W-1:0]  new_value;
    logic [RANK_W-1:0]        rank;
    logic                     out_valid;
    logic                     out_ready;
    logic [CNT_OUT_W-1:0]     zero_count;
    logic                     found;
    logic [IDX_W-1:0]         found_slot;

    // set during the stretch where neither side idles
    bit                       calm;
    int                       cycles;

    zero_table_tracker tracker = new();

    zero_count_segment_tree_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .left_or_slot (left_or_slot),
        .right_end    (right_end),
        .new_value    (new_value),
        .rank         (rank),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .zero_count   (zero_count),
        .found        (found),
        .found_slot   (found_slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // known values on every input from time zero
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        kind         = KIND_WRITE;
        left_or_slot = '0;
        right_end    = '0;
        new_value    = '0;
        rank         = '0;
        calm         = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, tracker.owed_answers.size());
            $display("zero_count_segment_tree_top regression: fail");
            $finish;
        end
    end
    initial cycles = 0;

    // both channels observed at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.take_item(kind, left_or_slot, right_end, new_value, rank);
            if (out_valid && out_ready)
                tracker.check_answer(zero_count, found, found_slot);
        end
    end

    // receiver: about a third of cycles stalled, rare long stalls,
    // never stalled while calm is set
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                stall_left = 0;
                out_ready  = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else if ($urandom_range(99) < 2)
            begin
                stall_left = $urandom_range(10, 40);
                out_ready  = 1'b0;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= 35);
            end
        end
    end

    // one input beat: optional idle gap, then hold valid until taken;
    // returns at the falling edge after the beat
    task automatic issue(input logic [KIND_W-1:0] k_kind, input int lo_slot,
                         input int hi_slot, input logic [VAL_W-1:0] value,
                         input int k_rank);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 35)
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind         = k_kind;
        left_or_slot = IDX_W'(lo_slot);
        right_end    = IDX_W'(hi_slot);
        new_value    = value;
        rank         = RANK_W'(k_rank);
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // sender holds off until every owed result is back and the block is quiet
    task automatic drain_results();
        in_valid = 1'b0;
        while (tracker.owed_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return '0;
            4:          return 32'h8000_0000;
            5:          return 32'h7FFF_FFFF;
            6:          return '1;
            7:          return 32'd1;
            default:    return $urandom;
        endcase
    endfunction

    task automatic pick_range(output int lo_slot, output int hi_slot);
        int a;
        int b;
        case ($urandom_range(9))
            0:
            begin
                lo_slot = 0;
                hi_slot = SLOTS - 1;
            end
            1:
            begin
                // empty range, left above right
                hi_slot = $urandom_range(0, SLOTS - 2);
                lo_slot = $urandom_range(hi_slot + 1, SLOTS - 1);
            end
            2:
            begin
                lo_slot = $urandom_range(0, SLOTS - 1);
                hi_slot = lo_slot;
            end
            3, 4, 5:
            begin
                lo_slot = $urandom_range(0, SLOTS - 1);
                hi_slot = lo_slot + $urandom_range(0, 15);
                if (hi_slot > SLOTS - 1)
                    hi_slot = SLOTS - 1;
            end
            default:
            begin
                a = $urandom_range(0, SLOTS - 1);
                b = $urandom_range(0, SLOTS - 1);
                lo_slot = (a < b) ? a : b;
                hi_slot = (a < b) ? b : a;
            end
        endcase
    endtask

    initial
    begin
        int items;
        int roll;
        int lo_slot;
        int hi_slot;
        int slot;
        int zeros;
        int k_rank;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fresh table is all zeros
        issue(KIND_COUNT, 0, SLOTS - 1, '0, 0);
        issue(KIND_FIND, 0, SLOTS - 1, '0, 1);
        issue(KIND_FIND, 0, SLOTS - 1, '0, SLOTS);
        issue(KIND_FIND, 0, SLOTS - 1, '0, 0);              // rank zero
        issue(KIND_FIND, 0, SLOTS - 1, '0, 2047);           // rank far too large
        issue(KIND_COUNT, 5, 4, '0, 0);                     // empty range
        issue(KIND_FIND, 700, 3, '0, 1);
        // value extremes, table edges and the midpoint split
        issue(KIND_WRITE, 0, 0, 32'h8000_0000, 0);
        issue(KIND_WRITE, SLOTS - 1, 0, 32'h7FFF_FFFF, 0);
        issue(KIND_WRITE, 512, 0, '1, 0);
        issue(KIND_WRITE, 511, 0, 32'd1, 0);
        issue(KIND_SPARE, 511, 1023, '1, 2047);             // dropped kind
        issue(KIND_WRITE, 511, 0, '0, 0);                   // back to zero
        issue(KIND_COUNT, 0, SLOTS - 1, '0, 0);
        issue(KIND_COUNT, SLOTS - 1, SLOTS - 1, '0, 0);
        issue(KIND_COUNT, 0, 0, '0, 0);
        issue(KIND_FIND, 0, SLOTS - 1, '0, 1);
        issue(KIND_FIND, 0, SLOTS - 1, '0, SLOTS - 3);      // last zero
        issue(KIND_FIND, 0, SLOTS - 1, '0, SLOTS - 2);      // one past it
        issue(KIND_FIND, 500, 600, '0, 12);
        issue(KIND_COUNT, 512, 512, '0, 0);
        issue(KIND_WRITE, 0, 0, '0, 0);
        issue(KIND_FIND, 0, 0, '0, 1);
        drain_results();

        // random part; the middle stretch runs with no idling on either side
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            calm = (items >= 400 && items < 700);
            if (items == 900 && tracker.owed_answers.size() != 0)
                drain_results();
            roll = $urandom_range(99);
            if (roll < 4)
            begin
                issue(KIND_SPARE, $urandom_range(0, SLOTS - 1), $urandom_range(0, SLOTS - 1),
                      $urandom, $urandom_range(0, 2047));
                continue;
            end
            if (roll < 50)
            begin
                case ($urandom_range(9))
                    0:       slot = 0;
                    1:       slot = SLOTS - 1;
                    default: slot = $urandom_range(0, SLOTS - 1);
                endcase
                issue(KIND_WRITE, slot, $urandom_range(0, SLOTS - 1), pick_value(),
                      $urandom_range(0, 2047));
            end
            else
            begin
                pick_range(lo_slot, hi_slot);
                if (roll < 74)
                begin
                    issue(KIND_COUNT, lo_slot, hi_slot, $urandom, $urandom_range(0, 2047));
                end
                else
                begin
                    zeros = (lo_slot > hi_slot) ? 0 : tracker.count_zeros(lo_slot, hi_slot);
                    if (zeros > 0 && $urandom_range(99) < 75)
                    begin
                        k_rank = $urandom_range(1, zeros);
                    end
                    else
                    begin
                        case ($urandom_range(2))
                            0:       k_rank = 0;
                            1:       k_rank = zeros + 1;
                            default: k_rank = $urandom_range(0, 2047);
                        endcase
                    end
                    issue(KIND_FIND, lo_slot, hi_slot, $urandom, k_rank);
                end
            end
            items++;
        end
        calm = 1'b0;

        // wait out the last results and any write still in progress
        drain_results();

        $display("covered %0d writes, %0d count queries, %0d rank searches (%0d located)",
                 tracker.writes, tracker.counts, tracker.finds, tracker.located);
        $display("%0d dropped beats, %0d result beats checked, %0d mismatches, %0d cycles",
                 tracker.spare_beats, tracker.checked, tracker.mismatches, cycles);
        if (tracker.mismatches == 0 && tracker.owed_answers.size() == 0)
            $display("zero_count_segment_tree_top regression: pass");
        else
            $display("zero_count_segment_tree_top regression: fail");
        $finish;
    end

endmodule
